[hdl/llp_pkg.sv]
// Shared constants, opcodes and controller/datapath interface types for the list partitioner.
package llp_pkg;

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned ADDR_W         = 10;
  localparam int unsigned PTR_W          = 11;
  localparam int unsigned KEY_W          = 18;
  localparam int unsigned THR_W          = 17;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned CLS_W          = 2;
  localparam int unsigned NODE_COUNT_DEF = 1024;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_PULL  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_NEG  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

  localparam logic [PTR_W-1:0] ADDR_NONE = '1;

  typedef struct packed {
    logic load;
    logic start;
    logic pull_rd;
    logic walk_rd;
    logic walk_ev;
    logic next_class;
    logic pull_key;
    logic pull_out;
  } llp_cmd_t;

  typedef struct packed {
    logic walk_more;
    logic last_class;
    logic out_free;
  } llp_status_t;

endpackage

[hdl/llp_ctrl.sv]
// Controller state machine that sequences loads, the partition walk and pulls.
module llp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [llp_pkg::OP_W-1:0] opcode_i,
  input  llp_pkg::llp_status_t    status_i,
  output llp_pkg::llp_cmd_t       cmd_o
);
  import llp_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_WALK_RD  = 3'd1;
  localparam logic [2:0] ST_WALK_EV  = 3'd2;
  localparam logic [2:0] ST_PULL_KEY = 3'd3;
  localparam logic [2:0] ST_PULL_OUT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_LOAD: cmd_o.load = 1'b1;
            OP_START: begin
              cmd_o.start = 1'b1;
              state_d     = ST_WALK_RD;
            end
            OP_PULL: begin
              cmd_o.pull_rd = 1'b1;
              state_d       = ST_PULL_KEY;
            end
            default: ;
          endcase
        end
      end
      ST_WALK_RD: begin
        if (status_i.walk_more) begin
          cmd_o.walk_rd = 1'b1;
          state_d       = ST_WALK_EV;
        end else if (status_i.last_class) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.next_class = 1'b1;
        end
      end
      ST_WALK_EV: begin
        cmd_o.walk_ev = 1'b1;
        state_d       = ST_WALK_RD;
      end
      ST_PULL_KEY: begin
        cmd_o.pull_key = 1'b1;
        state_d        = ST_PULL_OUT;
      end
      ST_PULL_OUT: begin
        if (status_i.out_free) begin
          cmd_o.pull_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/llp_datapath.sv]
// Datapath with the node tables, order table, walk counters and output register.
module llp_datapath #(
  parameter int unsigned NODE_COUNT = llp_pkg::NODE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  llp_pkg::llp_cmd_t                cmd_i,
  output llp_pkg::llp_status_t             status_o,
  input  logic                             cfg_valid_i,
  input  logic [llp_pkg::THR_W-1:0]        cfg_threshold_i,
  input  logic signed [llp_pkg::PTR_W-1:0] node_address_i,
  input  logic signed [llp_pkg::KEY_W-1:0] node_key_i,
  input  logic signed [llp_pkg::PTR_W-1:0] next_address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [llp_pkg::PTR_W-1:0] out_address_o,
  output logic signed [llp_pkg::KEY_W-1:0] out_key_o,
  output logic signed [llp_pkg::PTR_W-1:0] out_next_o,
  output logic                             is_last_o
);
  import llp_pkg::*;

  localparam int unsigned StepLimit = (NODE_COUNT < TABLE_DEPTH) ? NODE_COUNT : TABLE_DEPTH;
  localparam logic [PTR_W-1:0] StepLimitW = PTR_W'(StepLimit);

  logic [KEY_W-1:0]  key_mem   [TABLE_DEPTH];
  logic [PTR_W-1:0]  link_mem  [TABLE_DEPTH];
  logic [ADDR_W-1:0] order_mem [TABLE_DEPTH];

  logic [THR_W-1:0]  threshold_q;
  logic [PTR_W-1:0]  head_q, cur_q;
  logic [PTR_W-1:0]  steps_q, count_q, rp_q;
  logic [CLS_W-1:0]  cls_q;
  logic [KEY_W-1:0]  key_rd_q;
  logic [PTR_W-1:0]  link_rd_q;
  logic [ADDR_W-1:0] ord0_q, ord1_q;
  logic              out_valid_q;
  logic [PTR_W-1:0]  out_address_q, out_next_q;
  logic [KEY_W-1:0]  out_key_q;
  logic              is_last_q;

  logic [CLS_W-1:0]  key_cls;
  logic              cls_match;
  logic [PTR_W-1:0]  rp_inc;
  logic              avail;
  logic              last_node;
  logic [ADDR_W-1:0] key_raddr;

  // Class of the key just read for the node under the walk pointer.
  always_comb begin
    if (key_rd_q[KEY_W-1]) begin
      key_cls = CLS_NEG;
    end else if (key_rd_q[THR_W-1:0] <= threshold_q) begin
      key_cls = CLS_MID;
    end else begin
      key_cls = CLS_HIGH;
    end
  end

  assign cls_match = (key_cls == cls_q);
  assign rp_inc    = rp_q + PTR_W'(1);
  assign avail     = (rp_q < count_q);
  assign last_node = (rp_inc >= count_q);
  assign key_raddr = cmd_i.pull_key ? ord0_q : cur_q[ADDR_W-1:0];

  assign status_o.walk_more  = !cur_q[PTR_W-1] && (steps_q < StepLimitW);
  assign status_o.last_class = (cls_q == CLS_HIGH);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Node tables: written by loads, read by the walk and by pulls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !node_address_i[PTR_W-1]) begin
      key_mem[node_address_i[ADDR_W-1:0]]  <= node_key_i;
      link_mem[node_address_i[ADDR_W-1:0]] <= next_address_i;
    end
    if (cmd_i.walk_rd || cmd_i.pull_key) begin
      key_rd_q <= key_mem[key_raddr];
    end
    if (cmd_i.walk_rd) begin
      link_rd_q <= link_mem[cur_q[ADDR_W-1:0]];
    end
  end

  // Order table: appended by the walk, read at two positions by pulls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_ev && cls_match) begin
      order_mem[count_q[ADDR_W-1:0]] <= cur_q[ADDR_W-1:0];
    end
    if (cmd_i.pull_rd) begin
      ord0_q <= order_mem[rp_q[ADDR_W-1:0]];
      ord1_q <= order_mem[rp_inc[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      head_q <= node_address_i;
    end
    if (cmd_i.pull_out) begin
      if (avail) begin
        out_address_q <= {1'b0, ord0_q};
        out_key_q     <= key_rd_q;
        out_next_q    <= last_node ? ADDR_NONE : {1'b0, ord1_q};
        is_last_q     <= last_node;
      end else begin
        out_address_q <= ADDR_NONE;
        out_key_q     <= '0;
        out_next_q    <= ADDR_NONE;
        is_last_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      cur_q       <= ADDR_NONE;
      steps_q     <= '0;
      cls_q       <= CLS_NEG;
      count_q     <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        threshold_q <= cfg_threshold_i;
      end
      if (cmd_i.start) begin
        cur_q   <= node_address_i;
        steps_q <= '0;
        cls_q   <= CLS_NEG;
        count_q <= '0;
        rp_q    <= '0;
      end else if (cmd_i.next_class) begin
        cur_q   <= head_q;
        steps_q <= '0;
        cls_q   <= cls_q + CLS_W'(1);
      end else if (cmd_i.walk_ev) begin
        cur_q   <= link_rd_q;
        steps_q <= steps_q + PTR_W'(1);
        if (cls_match) begin
          count_q <= count_q + PTR_W'(1);
        end
      end
      if (cmd_i.pull_out && avail) begin
        rp_q <= rp_inc;
      end
      if (cmd_i.pull_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_address_o = out_address_q;
  assign out_key_o     = out_key_q;
  assign out_next_o    = out_next_q;
  assign is_last_o     = is_last_q;

endmodule

[hdl/linked_list_three_way_partition.sv]
// Top level of the stable three-way linked list partitioner.
// Each input word carries an opcode. A load word writes one node (key and
// successor address) into a 1024-entry table; a negative slot address is
// ignored. A start word walks the list from the given head and builds a
// new order in a separate table: negative keys first, then keys from zero
// up to the threshold register, then the rest, each class in list order.
// The walk makes three passes over the list, one per class; each visited
// node takes a table read, then the class check and append. The walk
// ends at a negative successor or after min(NODE_COUNT, 1024) nodes per
// pass, so a cyclic list cannot hang the block. A pull word returns one
// output word: the next node of the new order with its current key and its
// relinked successor, or address -1 once the order is used up. A pull reads
// the order table, then the key table, then waits as needed for the output
// register to drain. Words of opcode 3 are accepted and ignored. The output
// register lets the next input word be accepted while a result still waits
// to be taken. The threshold register is written through its own port and
// must only change while the block is idle. The node tables hold no reset
// value; reading a never loaded node is undefined.
module linked_list_three_way_partition #(
  parameter int unsigned NODE_COUNT = llp_pkg::NODE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [llp_pkg::THR_W-1:0]        cfg_threshold_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [llp_pkg::OP_W-1:0]         opcode_i,
  input  logic signed [llp_pkg::PTR_W-1:0] node_address_i,
  input  logic signed [llp_pkg::KEY_W-1:0] node_key_i,
  input  logic signed [llp_pkg::PTR_W-1:0] next_address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [llp_pkg::PTR_W-1:0] out_address_o,
  output logic signed [llp_pkg::KEY_W-1:0] out_key_o,
  output logic signed [llp_pkg::PTR_W-1:0] out_next_o,
  output logic                             is_last_o
);
  import llp_pkg::*;

  llp_cmd_t    cmd;
  llp_status_t status;

  // The threshold register can always take a write.
  assign cfg_ready_o = 1'b1;

  llp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  llp_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_threshold_i (cfg_threshold_i),
    .node_address_i  (node_address_i),
    .node_key_i      (node_key_i),
    .next_address_i  (next_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_address_o   (out_address_o),
    .out_key_o       (out_key_o),
    .out_next_o      (out_next_o),
    .is_last_o       (is_last_o)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the stable three-way linked list partitioner.
module tb_top;
  import llp_pkg::*;

  // The walk visits at most this many nodes per pass, so a cyclic list ends.
  localparam int unsigned NODE_COUNT_TB = NODE_COUNT_DEF;
  localparam int unsigned STEP_LIMIT =
      (NODE_COUNT_TB < TABLE_DEPTH) ? NODE_COUNT_TB : TABLE_DEPTH;
  // A start gives no result word and runs three passes over the list, one per class.
  // SETTLE_CYCLES covers such a walk; wait that long whenever the block must be idle.
  localparam int unsigned SETTLE_CYCLES = 6 * STEP_LIMIT + 64;
  localparam int unsigned CYCLE_LIMIT = 25_000_000;
  localparam int unsigned WORDS_PER_PHASE = 120;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam int KEY_MIN = -(1 << (KEY_W - 1));
  localparam int KEY_MAX = (1 << (KEY_W - 1)) - 1;

  typedef logic signed [PTR_W-1:0] ptr_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ADDR_W-1:0] slot_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    ptr_t            addr;
    key_t            key;
    ptr_t            next;
  } node_word_t;

  typedef struct packed {
    ptr_t addr;
    key_t key;
    ptr_t next;
    logic last;
  } emit_t;

  // Output stall patterns; the monitor switches between them every so often.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [THR_W-1:0] cfg_threshold_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [OP_W-1:0]  opcode_i = OP_LOAD;
  ptr_t             node_address_i = '0;
  key_t             node_key_i = '0;
  ptr_t             next_address_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  ptr_t             out_address_o;
  key_t             out_key_o;
  ptr_t             out_next_o;
  logic             is_last_o;

  linked_list_three_way_partition #(
    .NODE_COUNT(NODE_COUNT_TB)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_threshold_i(cfg_threshold_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .node_address_i (node_address_i),
    .node_key_i     (node_key_i),
    .next_address_i (next_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_address_o  (out_address_o),
    .out_key_o      (out_key_o),
    .out_next_o     (out_next_o),
    .is_last_o      (is_last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Partition predictor. It keeps its own copy of the node tables, the built
  // order and the threshold, and is advanced once per accepted input word.
  // ---------------------------------------------------------------------------
  key_t             key_mem   [TABLE_DEPTH];
  ptr_t             link_mem  [TABLE_DEPTH];
  slot_t            order_mem [TABLE_DEPTH];
  int unsigned      order_len = 0;
  int unsigned      read_pos = 0;
  logic [THR_W-1:0] thr_model = '0;
  emit_t            expected_emits[$];

  function automatic logic [CLS_W-1:0] key_class(key_t k);
    if (k[KEY_W-1]) return CLS_NEG;
    if (k[KEY_W-2:0] <= thr_model) return CLS_MID;
    return CLS_HIGH;
  endfunction

  task automatic predict_partition(input node_word_t w);
    slot_t            visited[$];
    ptr_t             cursor;
    slot_t            node;
    emit_t            e;
    logic [CLS_W-1:0] class_seq [3];
    class_seq = '{CLS_NEG, CLS_MID, CLS_HIGH};
    case (w.op)
      OP_LOAD: begin
        // A negative slot address drops the whole word.
        if (!w.addr[PTR_W-1]) begin
          key_mem[w.addr[ADDR_W-1:0]] = w.key;
          link_mem[w.addr[ADDR_W-1:0]] = w.next;
        end
      end
      OP_START: begin
        // Follow the links until a negative successor or the step limit, then
        // emit the visited nodes class by class, each class in visit order.
        cursor = w.addr;
        while (!cursor[PTR_W-1] && visited.size() < STEP_LIMIT) begin
          visited = {visited, cursor[ADDR_W-1:0]};
          cursor = link_mem[cursor[ADDR_W-1:0]];
        end
        order_len = 0;
        foreach (class_seq[c]) begin
          foreach (visited[i]) begin
            if (key_class(key_mem[visited[i]]) == class_seq[c]) begin
              order_mem[order_len] = visited[i];
              order_len++;
            end
          end
        end
        read_pos = 0;
      end
      OP_PULL: begin
        if (read_pos < order_len) begin
          // The key is read at pull time, so a reload after the start shows.
          node   = order_mem[read_pos];
          e.addr = ptr_t'({1'b0, node});
          e.key  = key_mem[node];
          e.last = (read_pos + 1 >= order_len);
          e.next = e.last ? ADDR_NONE : ptr_t'({1'b0, order_mem[read_pos + 1]});
          read_pos++;
        end else begin
          // Order used up, or no start yet: an empty marker word.
          e.addr = ADDR_NONE;
          e.key  = '0;
          e.next = ADDR_NONE;
          e.last = 1'b0;
        end
        expected_emits = {expected_emits, e};
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Words come from pending_words in order; the sender runs in
  // bursts of random length with random gaps, and holds a word until taken.
  // ---------------------------------------------------------------------------
  node_word_t  pending_words[$];
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : word_driver
    node_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_partition(node_word_t'({opcode_i, node_address_i, node_key_i,
                                        next_address_i}));
        words_accepted++;
      end
      // The valid line may only change once the current word has gone.
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          opcode_i       <= w.op;
          node_address_i <= w.addr;
          node_key_i     <= w.key;
          next_address_i <= w.next;
          in_valid_i     <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and checker. Each accepted result word is compared with the
  // oldest expectation; the ready line follows a stall pattern of its own.
  // ---------------------------------------------------------------------------
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  int unsigned stall_left = 0;

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : result_monitor
    emit_t got;
    emit_t want;
    cycle_count++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_address_o, out_key_o, out_next_o, is_last_o};
      if (expected_emits.size() == 0) begin
        report_failure($sformatf("unexpected result word: addr %0d key %0d next %0d last %0b",
                                 $signed(got.addr), $signed(got.key), $signed(got.next),
                                 got.last));
      end else begin
        want = expected_emits.pop_front();
        if (got != want) begin
          report_failure($sformatf({"result mismatch: expected addr %0d key %0d next %0d",
                                    " last %0b, got addr %0d key %0d next %0d last %0b"},
                                   $signed(want.addr), $signed(want.key),
                                   $signed(want.next), want.last, $signed(got.addr),
                                   $signed(got.key), $signed(got.next), got.last));
        end
      end
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: begin
          // Mostly ready, now and then a long stall.
          if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator tracks which table slots have been
  // loaded so that no walk ever reaches a slot that was never written: each
  // loaded successor is negative, the node itself, a node of the same list,
  // or a slot that already holds a node.
  // ---------------------------------------------------------------------------
  logic [TABLE_DEPTH-1:0] gen_written = '0;
  slot_t                  written_slots[$];
  logic [THR_W-1:0]       gen_thr = '0;
  int unsigned            phase_words = 0;

  task automatic push_word(input logic [OP_W-1:0] op, input ptr_t addr, input key_t key,
                           input ptr_t next);
    pending_words = {pending_words, node_word_t'({op, addr, key, next})};
    words_queued++;
    // Words that the block ignores do not count toward the phase size.
    if (!(op == OP_UNUSED || (op == OP_LOAD && addr[PTR_W-1]))) phase_words++;
    if (op == OP_LOAD && !addr[PTR_W-1] && !gen_written[addr[ADDR_W-1:0]]) begin
      gen_written[addr[ADDR_W-1:0]] = 1'b1;
      written_slots = {written_slots, addr[ADDR_W-1:0]};
    end
  endtask

  task automatic load_node(input slot_t slot, input key_t key, input ptr_t next);
    push_word(OP_LOAD, ptr_t'({1'b0, slot}), key, next);
  endtask

  task automatic start_walk(input ptr_t head);
    push_word(OP_START, head, key_t'($urandom), ptr_t'($urandom));
  endtask

  task automatic pull_next();
    push_word(OP_PULL, ptr_t'($urandom), key_t'($urandom), ptr_t'($urandom));
  endtask

  function automatic ptr_t any_negative();
    return ptr_t'(-int'($urandom_range(1, 1 << (PTR_W - 1))));
  endfunction

  function automatic ptr_t any_written();
    return ptr_t'({1'b0, written_slots[$urandom_range(0, written_slots.size() - 1)]});
  endfunction

  // Keys cluster on the class borders of the current threshold.
  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0: return key_t'($urandom);
      1: return key_t'(-1);
      2: return key_t'(KEY_MIN);
      3: return key_t'(0);
      4: return key_t'({1'b0, gen_thr});
      5: return (gen_thr == THR_MAX) ? key_t'(KEY_MAX) : key_t'(int'(gen_thr) + 1);
      6: return key_t'(KEY_MAX);
      7: return key_t'($urandom_range(0, gen_thr));
      8: return (gen_thr == THR_MAX) ? key_t'(KEY_MAX)
                                     : key_t'($urandom_range(int'(gen_thr) + 1, KEY_MAX));
      default: return key_t'(-int'($urandom_range(1, 1 << (KEY_W - 1))));
    endcase
  endfunction

  function automatic ptr_t safe_link(input slot_t self);
    case ($urandom_range(0, 3))
      0: return ADDR_NONE;
      1: return any_negative();
      2: return ptr_t'({1'b0, self});
      default: return (written_slots.size() > 0) ? any_written() : ADDR_NONE;
    endcase
  endfunction

  task automatic push_ignored();
    if ($urandom_range(0, 1) == 0) begin
      push_word(OP_UNUSED, ptr_t'($urandom), key_t'($urandom), ptr_t'($urandom));
    end else begin
      push_word(OP_LOAD, any_negative(), key_t'($urandom), ptr_t'($urandom));
    end
  endtask

  task automatic gen_directed();
    pull_next();                                   // pull before any start
    push_word(OP_UNUSED, ptr_t'(5), key_t'(KEY_MAX), ptr_t'(5));
    push_word(OP_LOAD, ADDR_NONE, key_t'(KEY_MAX), ptr_t'(0));
    push_word(OP_LOAD, ptr_t'(11'h400), key_t'(KEY_MIN), ptr_t'(11'h3FF));
    start_walk(ADDR_NONE);                         // empty list
    pull_next();
    // Five nodes covering the key extremes; the tail ends on -1024.
    load_node(slot_t'(1023), key_t'(KEY_MIN), ptr_t'(0));
    load_node(slot_t'(0), key_t'(KEY_MAX), ptr_t'(5));
    load_node(slot_t'(5), key_t'(0), ptr_t'(7));
    load_node(slot_t'(7), key_t'(-1), ptr_t'(512));
    load_node(slot_t'(512), key_t'(1), ptr_t'(11'h400));
    start_walk(ptr_t'(1023));
    repeat (4) pull_next();
    // Reload after the start: the order stays, the new key shows on the pull.
    load_node(slot_t'(512), key_t'(-5), ADDR_NONE);
    pull_next();
    pull_next();                                   // exhausted pull
    // A two-node cycle runs into the step limit.
    load_node(slot_t'(300), key_t'(3), ptr_t'(301));
    load_node(slot_t'(301), key_t'(-3), ptr_t'(300));
    start_walk(ptr_t'(300));
    repeat (3) pull_next();
  endtask

  // Load one list in shuffled order, start at its head, then pull it out with
  // an occasional reload of one of its nodes in between.
  task automatic gen_list_run();
    slot_t       slots[$];
    ptr_t        links[$];
    int          order[$];
    int          len;
    int          pulls;
    int          i;
    int          j;
    int          t;
    int          pick;
    int unsigned r;
    r = $urandom_range(0, 99);
    len = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    for (i = 0; i < len; i++) slots = {slots, slot_t'($urandom_range(0, TABLE_DEPTH - 1))};
    for (i = 0; i < len; i++) begin
      if (i < len - 1) begin
        links = {links, ptr_t'({1'b0, slots[i + 1]})};
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) links = {links, ADDR_NONE};
        else if (r < 75) links = {links, any_negative()};
        else if (r < 92 && written_slots.size() > 0) links = {links, any_written()};
        else links = {links, ptr_t'({1'b0, slots[$urandom_range(0, len - 1)]})};
      end
    end
    for (i = 0; i < len; i++) order = {order, i};
    for (i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[k]) begin
      load_node(slots[order[k]], pick_key(), links[order[k]]);
      if ($urandom_range(0, 19) == 0) push_ignored();
    end
    if (len > 0) start_walk(ptr_t'({1'b0, slots[0]}));
    else start_walk(($urandom_range(0, 1) == 0) ? ADDR_NONE : any_negative());
    if (len == 0) pulls = $urandom_range(1, 2);
    else if ($urandom_range(0, 9) < 7) pulls = len + $urandom_range(0, 2);
    else pulls = $urandom_range(1, len);
    for (i = 0; i < pulls; i++) begin
      if (len > 0 && $urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, len - 1);
        load_node(slots[pick], pick_key(), links[pick]);
      end
      pull_next();
    end
  endtask

  // A short cycle walked to the step limit, then the head of its order pulled.
  task automatic gen_cyclic_drain();
    slot_t slots[$];
    int    len;
    int    i;
    len = $urandom_range(2, 5);
    for (i = 0; i < len; i++) slots = {slots, slot_t'($urandom_range(0, TABLE_DEPTH - 1))};
    for (i = 0; i < len; i++) begin
      load_node(slots[i], pick_key(), ptr_t'({1'b0, slots[(i + 1) % len]}));
    end
    start_walk(ptr_t'({1'b0, slots[0]}));
    repeat ($urandom_range(4, 16)) pull_next();
  endtask

  task automatic gen_random_phase(input bit with_drain);
    int unsigned r;
    slot_t       slot;
    phase_words = 0;
    while (phase_words < WORDS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        gen_list_run();
      end else if (r < 75) begin
        // Restart on whatever chain a loaded slot leads into, or on an empty list.
        if ($urandom_range(0, 3) != 0) start_walk(any_written());
        else start_walk(any_negative());
        repeat ($urandom_range(0, 4)) pull_next();
      end else if (r < 85) begin
        push_ignored();
        slot = slot_t'($urandom_range(0, TABLE_DEPTH - 1));
        load_node(slot, pick_key(), safe_link(slot));
      end else begin
        repeat ($urandom_range(1, 4)) pull_next();
      end
    end
    if (with_drain) gen_cyclic_drain();
    pull_next();
  endtask

  // Wait until every word is taken and every result checked, then give a
  // trailing walk time to finish.
  task automatic settle();
    while (words_accepted != words_queued || expected_emits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_threshold_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_model = value;
    gen_thr = value;
  endtask

  // Phases run at the reset threshold, then at both extremes, then at a
  // random value over the full range and at a small one.
  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    gen_directed();
    gen_random_phase(1'b0);
    settle();
    write_threshold(THR_MAX);
    gen_random_phase(1'b1);
    settle();
    write_threshold('0);
    gen_random_phase(1'b0);
    settle();
    write_threshold(THR_W'($urandom_range(1, THR_MAX - 1)));
    gen_random_phase(1'b0);
    settle();
    write_threshold(THR_W'($urandom_range(0, 64)));
    gen_random_phase(1'b0);
    settle();
    if (expected_emits.size() != 0) begin
      report_failure($sformatf("%0d result words never arrived", expected_emits.size()));
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/llp_pkg.sv
hdl/llp_ctrl.sv
hdl/llp_datapath.sv
hdl/linked_list_three_way_partition.sv
verif/tb_top.sv
